FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Types and constants shared by the particle integrator modules.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int SIZE_W    = 16;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEPS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 4;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SPAWN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_RATE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_CHANGE  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_WIDTH  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_WIDTH    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_HEIGHT   = 4'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_DIV_INIT,
    ST_DIV,
    ST_SQUARE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } pes_state_t;

  typedef struct packed {
    logic load_spawn;
    logic mark_dead;
    logic upd_vel;
    logic upd_pos;
    logic div_init;
    logic div_step;
    logic square;
    logic lerp_mul;
    logic lerp_add;
    logic out_load;
  } pes_cmd_t;

  typedef struct packed {
    logic life_zero;
    logic size_on;
  } pes_status_t;

endpackage

FILE: rtl/pes_ctrl.sv
// ----------------------------------------------------------------------------
// pes_ctrl
// Controller: sequences spawn, tick, divide, square and size steps.
// ----------------------------------------------------------------------------
module pes_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pes_pkg::pes_status_t status,
  output pes_pkg::pes_cmd_t    cmd
);
  import pes_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  pes_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_SPAWN || status.life_zero) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_POS;
          end
        end
      end
      ST_POS: begin
        state_nxt = status.size_on ? ST_DIV_INIT : ST_DONE;
      end
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_SPAWN) begin
            cmd.load_spawn = 1'b1;
          end else if (status.life_zero) begin
            cmd.mark_dead = 1'b1;
          end else begin
            cmd.upd_vel = 1'b1;
          end
        end
      end
      ST_POS:      cmd.upd_pos  = 1'b1;
      ST_DIV_INIT: cmd.div_init = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_SQUARE:   cmd.square   = 1'b1;
      ST_MUL:      cmd.lerp_mul = 1'b1;
      ST_ADD:      cmd.lerp_add = 1'b1;
      ST_DONE:     cmd.out_load = out_free;
      default:     cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_DIV) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/pes_datapath.sv
// ----------------------------------------------------------------------------
// pes_datapath
// Particle state, configuration, serial divider, size multipliers and the
// output register.
// ----------------------------------------------------------------------------
module pes_datapath #(
  parameter int LIFE_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic signed [31:0]            in_spawn_pos_x,
  input  logic signed [31:0]            in_spawn_pos_y,
  input  logic signed [31:0]            in_spawn_vel_x,
  input  logic signed [31:0]            in_spawn_vel_y,
  input  logic signed [31:0]            in_spawn_angle,
  input  logic [15:0]                   in_spawn_life,
  input  pes_pkg::pes_cmd_t             cmd,
  output pes_pkg::pes_status_t          status,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_angle,
  output logic [15:0]                   out_width,
  output logic [15:0]                   out_height,
  output logic                          out_is_dead
);
  import pes_pkg::*;

  localparam int PROD_W = SIZE_W + T_W + 2;
  localparam int SQ_W   = 2 * T_W;

  function automatic logic [COORD_BITS-1:0] widen(input logic [31:0] v);
    logic signed [COORD_BITS+31:0] t;
    t = (COORD_BITS + 32)'(signed'(v));
    return t[COORD_BITS-1:0];
  endfunction

  function automatic logic [31:0] low32(input logic [COORD_BITS-1:0] v);
    logic [COORD_BITS+31:0] t;
    t = (COORD_BITS + 32)'(v);
    return t[31:0];
  endfunction

  logic [31:0]           gravity_x_r, gravity_y_r, spin_rate_r;
  logic                  size_change_r;
  logic [SIZE_W-1:0]     start_w_r, start_h_r, end_w_r, end_h_r;

  logic [COORD_BITS-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, angle_r;
  logic [LIFE_BITS-1:0]  life_left_r, life_total_r;
  logic [SIZE_W-1:0]     width_r, height_r;
  logic                  dead_r;

  logic [LIFE_BITS-1:0]  rem_r;
  logic [T_W-1:0]        q_r;
  logic [T_W-1:0]        t2_r;
  logic [PROD_W-1:0]     prod_w_r, prod_h_r;

  logic [31:0]           o_pos_x_r, o_pos_y_r, o_angle_r;
  logic [SIZE_W-1:0]     o_width_r, o_height_r;
  logic                  o_dead_r;

  logic [LIFE_BITS+15:0] life_ext;
  logic [LIFE_BITS-1:0]  life_ld;
  logic [LIFE_BITS-1:0]  elapsed;
  logic                  q_top;
  logic [LIFE_BITS-1:0]  rem_init;
  logic [LIFE_BITS:0]    rem_dbl;
  logic [LIFE_BITS:0]    rem_sub;
  logic                  q_bit;
  logic [SQ_W-1:0]       sq;
  logic signed [SIZE_W:0] diff_w, diff_h;
  logic signed [PROD_W-1:0] prod_w_nxt, prod_h_nxt;

  assign cfg_ready = 1'b1;

  assign life_ext = (LIFE_BITS + 16)'(in_spawn_life);
  assign life_ld  = life_ext[LIFE_BITS-1:0];

  assign elapsed  = (life_total_r > life_left_r) ? (life_total_r - life_left_r) : '0;
  assign q_top    = (elapsed >= life_total_r);
  assign rem_init = q_top ? (elapsed - life_total_r) : elapsed;

  assign rem_dbl  = {rem_r, 1'b0};
  assign rem_sub  = rem_dbl - {1'b0, life_total_r};
  assign q_bit    = (life_total_r != '0) && (rem_dbl >= {1'b0, life_total_r});

  assign sq       = SQ_W'(q_r) * SQ_W'(q_r);

  assign diff_w     = signed'({1'b0, end_w_r}) - signed'({1'b0, start_w_r});
  assign diff_h     = signed'({1'b0, end_h_r}) - signed'({1'b0, start_h_r});
  assign prod_w_nxt = diff_w * signed'({1'b0, t2_r});
  assign prod_h_nxt = diff_h * signed'({1'b0, t2_r});

  assign status.life_zero = (life_left_r == '0);
  assign status.size_on   = size_change_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_x_r   <= '0;
      gravity_y_r   <= '0;
      spin_rate_r   <= '0;
      size_change_r <= 1'b0;
      start_w_r     <= '0;
      start_h_r     <= '0;
      end_w_r       <= '0;
      end_h_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRAVITY_X:    gravity_x_r   <= cfg_data;
        REG_GRAVITY_Y:    gravity_y_r   <= cfg_data;
        REG_SPIN_RATE:    spin_rate_r   <= cfg_data;
        REG_SIZE_CHANGE:  size_change_r <= cfg_data[0];
        REG_START_WIDTH:  start_w_r     <= cfg_data[SIZE_W-1:0];
        REG_START_HEIGHT: start_h_r     <= cfg_data[SIZE_W-1:0];
        REG_END_WIDTH:    end_w_r       <= cfg_data[SIZE_W-1:0];
        REG_END_HEIGHT:   end_h_r       <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      angle_r      <= '0;
      life_left_r  <= '0;
      life_total_r <= '0;
      width_r      <= '0;
      height_r     <= '0;
      dead_r       <= 1'b0;
    end else begin
      if (cmd.load_spawn) begin
        pos_x_r      <= widen(in_spawn_pos_x);
        pos_y_r      <= widen(in_spawn_pos_y);
        vel_x_r      <= widen(in_spawn_vel_x);
        vel_y_r      <= widen(in_spawn_vel_y);
        angle_r      <= widen(in_spawn_angle);
        life_left_r  <= life_ld;
        life_total_r <= life_ld;
        width_r      <= start_w_r;
        height_r     <= start_h_r;
        dead_r       <= 1'b0;
      end
      if (cmd.mark_dead) begin
        dead_r <= 1'b1;
      end
      if (cmd.upd_vel) begin
        life_left_r <= life_left_r - LIFE_BITS'(1);
        angle_r     <= angle_r + widen(spin_rate_r);
        vel_x_r     <= vel_x_r + widen(gravity_x_r);
        vel_y_r     <= vel_y_r + widen(gravity_y_r);
      end
      if (cmd.upd_pos) begin
        pos_x_r <= pos_x_r + vel_x_r;
        pos_y_r <= pos_y_r + vel_y_r;
      end
      if (cmd.lerp_add) begin
        width_r  <= start_w_r + prod_w_r[FRAC_BITS+SIZE_W-1:FRAC_BITS];
        height_r <= start_h_r + prod_h_r[FRAC_BITS+SIZE_W-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= rem_init;
      q_r   <= T_W'(q_top);
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[LIFE_BITS-1:0] : rem_dbl[LIFE_BITS-1:0];
      q_r   <= {q_r[T_W-2:0], q_bit};
    end
    if (cmd.square) begin
      t2_r <= sq[FRAC_BITS+T_W-1:FRAC_BITS];
    end
    if (cmd.lerp_mul) begin
      prod_w_r <= prod_w_nxt;
      prod_h_r <= prod_h_nxt;
    end
    if (cmd.out_load) begin
      o_pos_x_r  <= low32(pos_x_r);
      o_pos_y_r  <= low32(pos_y_r);
      o_angle_r  <= low32(angle_r);
      o_width_r  <= width_r;
      o_height_r <= height_r;
      o_dead_r   <= dead_r;
    end
  end

  assign out_pos_x   = o_pos_x_r;
  assign out_pos_y   = o_pos_y_r;
  assign out_angle   = o_angle_r;
  assign out_width   = o_width_r;
  assign out_height  = o_height_r;
  assign out_is_dead = o_dead_r;

endmodule

FILE: rtl/particle_euler_step_with_lifetime.sv
// ----------------------------------------------------------------------------
// particle_euler_step_with_lifetime
// One 2-D particle with Euler integration, a lifetime and eased size change.
// ----------------------------------------------------------------------------
// The input channel takes one item at a time: a spawn loads the particle, a
// tick advances it by one frame. Each item returns one result item holding
// position, angle, size and the dead flag after that item.
// Spawn items and ticks at zero life go from acceptance straight to the done
// state, which loads the output register. A live tick adds the velocity at
// acceptance; then come the position add and, with size change on, the divider
// setup, 16 restoring divider steps for the elapsed fraction, the square of
// it, the two size multiplies and the final add; last the output register is
// loaded. Once the result is loaded the block returns to idle and accepts the
// next item.
// The configuration port accepts a write every cycle; writes are expected
// only while the block is idle. Indexes past the last register are ignored.
// Reset clears the particle state, the configuration and the output valid.
// A stalled receiver holds the result in the output register; the block
// still accepts one further item and parks its result until the register
// frees up.
// ----------------------------------------------------------------------------
module particle_euler_step_with_lifetime #(
  parameter int LIFE_BITS  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [31:0]            in_spawn_pos_x,
  input  logic signed [31:0]            in_spawn_pos_y,
  input  logic signed [31:0]            in_spawn_vel_x,
  input  logic signed [31:0]            in_spawn_vel_y,
  input  logic signed [31:0]            in_spawn_angle,
  input  logic [15:0]                   in_spawn_life,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_angle,
  output logic [15:0]                   out_width,
  output logic [15:0]                   out_height,
  output logic                          out_is_dead
);
  import pes_pkg::*;

  `include "assert_macros.svh"

  pes_cmd_t    cmd;
  pes_status_t status;

  pes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pes_datapath #(
    .LIFE_BITS  (LIFE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_spawn_pos_x (in_spawn_pos_x),
    .in_spawn_pos_y (in_spawn_pos_y),
    .in_spawn_vel_x (in_spawn_vel_x),
    .in_spawn_vel_y (in_spawn_vel_y),
    .in_spawn_angle (in_spawn_angle),
    .in_spawn_life  (in_spawn_life),
    .cmd            (cmd),
    .status         (status),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_angle      (out_angle),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_is_dead    (out_is_dead)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted item did not leave idle")
  `ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd), "more than one datapath command at once")
  `ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "output register overwritten")
  `ASSERT_NEXT(a_load_shows_valid, cmd.out_load, out_valid, "loaded result not presented")

endmodule

FILE: tb/tb_particle_euler_step_with_lifetime.sv
// ----------------------------------------------------------------------------
// tb_particle_euler_step_with_lifetime
// Self-checking bench for the single-particle integrator with lifetime.
// ----------------------------------------------------------------------------
// Spawn and tick items are driven in random bursts while the result side
// stalls on its own pattern. A behavioral copy of the particle predicts the
// state after every accepted item. Results are compared field by field in
// order. Directed tests cover reset state, field extremes, wrapping, death
// and eased sizing. A long random run then spawns particles and ticks them,
// mostly to death, under changing register settings.
// ----------------------------------------------------------------------------
module tb_particle_euler_step_with_lifetime;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_REPORTS     = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 108;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  typedef struct packed {
    logic [31:0] gravity_x;
    logic [31:0] gravity_y;
    logic [31:0] spin_rate;
    logic        size_on;
    logic [15:0] start_width;
    logic [15:0] start_height;
    logic [15:0] end_width;
    logic [15:0] end_height;
  } field_cfg_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] angle;
    logic [15:0] life_left;
    logic [15:0] life_total;
    logic [15:0] width;
    logic [15:0] height;
    logic        dead;
  } particle_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] angle;
    logic [15:0] life;
  } particle_item_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] angle;
    logic [15:0] width;
    logic [15:0] height;
    logic        dead;
  } particle_view_t;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_STALLS} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic signed [31:0]   in_spawn_pos_x;
  logic signed [31:0]   in_spawn_pos_y;
  logic signed [31:0]   in_spawn_vel_x;
  logic signed [31:0]   in_spawn_vel_y;
  logic signed [31:0]   in_spawn_angle;
  logic [15:0]          in_spawn_life;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [31:0]   out_pos_x;
  logic signed [31:0]   out_pos_y;
  logic signed [31:0]   out_angle;
  logic [15:0]          out_width;
  logic [15:0]          out_height;
  logic                 out_is_dead;

  field_cfg_t     cfg_model = '0;
  particle_t      particle  = '0;
  particle_item_t seen_item;
  particle_view_t want;
  particle_view_t pending_states[$];

  int mismatches   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;
  int n_spawns     = 0;
  int n_ticks      = 0;
  int n_dead_ticks = 0;
  int n_settings   = 0;
  int n_results    = 0;

  rx_mode_t rx_mode      = RX_STEADY;
  int       rx_mode_left = 0;
  int       rx_hold      = 0;
  logic     rx_stalled   = 1'b0;

  particle_euler_step_with_lifetime dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_spawn_pos_x (in_spawn_pos_x),
    .in_spawn_pos_y (in_spawn_pos_y),
    .in_spawn_vel_x (in_spawn_vel_x),
    .in_spawn_vel_y (in_spawn_vel_y),
    .in_spawn_angle (in_spawn_angle),
    .in_spawn_life  (in_spawn_life),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_angle      (out_angle),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_is_dead    (out_is_dead)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [15:0] eased_size(logic [15:0] from, logic [15:0] to,
                                             logic [16:0] t2);
    logic signed [35:0] prod;
    prod = ($signed({20'd0, to}) - $signed({20'd0, from})) * $signed({19'd0, t2});
    return from + prod[31:16];
  endfunction

  function automatic particle_t step_particle(particle_t p, field_cfg_t c,
                                              particle_item_t it);
    particle_t   n;
    logic [15:0] elapsed;
    logic [16:0] t1;
    logic [16:0] t2;
    logic [33:0] sq;
    n = p;
    if (it.cmd == CMD_SPAWN) begin
      n.pos_x      = it.pos_x;
      n.pos_y      = it.pos_y;
      n.vel_x      = it.vel_x;
      n.vel_y      = it.vel_y;
      n.angle      = it.angle;
      n.life_left  = it.life;
      n.life_total = it.life;
      n.width      = c.start_width;
      n.height     = c.start_height;
      n.dead       = 1'b0;
    end else if (p.life_left != 16'd0) begin
      n.life_left = p.life_left - 16'd1;
      if (c.size_on) begin
        if (n.life_total == 16'd0) begin
          t1 = 17'h10000;
        end else begin
          elapsed = (n.life_total > n.life_left) ? n.life_total - n.life_left : 16'd0;
          t1 = 17'({elapsed, 16'h0000} / {16'h0000, n.life_total});
        end
        sq       = t1 * t1;
        t2       = 17'(sq >> 16);
        n.width  = eased_size(c.start_width, c.end_width, t2);
        n.height = eased_size(c.start_height, c.end_height, t2);
      end
      n.angle = p.angle + c.spin_rate;
      n.vel_x = p.vel_x + c.gravity_x;
      n.vel_y = p.vel_y + c.gravity_y;
      n.pos_x = p.pos_x + n.vel_x;
      n.pos_y = p.pos_y + n.vel_y;
    end else begin
      n.dead = 1'b1;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  // Register writes, result checking and prediction all happen on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY_X:    cfg_model.gravity_x    = cfg_data;
          REG_GRAVITY_Y:    cfg_model.gravity_y    = cfg_data;
          REG_SPIN_RATE:    cfg_model.spin_rate    = cfg_data;
          REG_SIZE_CHANGE:  cfg_model.size_on      = cfg_data[0];
          REG_START_WIDTH:  cfg_model.start_width  = cfg_data[15:0];
          REG_START_HEIGHT: cfg_model.start_height = cfg_data[15:0];
          REG_END_WIDTH:    cfg_model.end_width    = cfg_data[15:0];
          REG_END_HEIGHT:   cfg_model.end_height   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_states.size() == 0) begin
          report_mismatch("result item arrived with no item outstanding");
        end else begin
          want = pending_states.pop_front();
          if (out_pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %h want %h", out_pos_x, want.pos_x));
          if (out_pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %h want %h", out_pos_y, want.pos_y));
          if (out_angle !== want.angle)
            report_mismatch($sformatf("angle got %h want %h", out_angle, want.angle));
          if (out_width !== want.width)
            report_mismatch($sformatf("width got %h want %h", out_width, want.width));
          if (out_height !== want.height)
            report_mismatch($sformatf("height got %h want %h", out_height, want.height));
          if (out_is_dead !== want.dead)
            report_mismatch($sformatf("is_dead got %b want %b", out_is_dead, want.dead));
        end
      end
      if (in_valid && in_ready) begin
        seen_item = '{in_cmd, in_spawn_pos_x, in_spawn_pos_y, in_spawn_vel_x,
                      in_spawn_vel_y, in_spawn_angle, in_spawn_life};
        if (in_cmd == CMD_SPAWN) begin
          n_spawns++;
        end else begin
          n_ticks++;
          if (particle.life_left == 16'd0) n_dead_ticks++;
        end
        particle = step_particle(particle, cfg_model, seen_item);
        pending_states.push_back('{particle.pos_x, particle.pos_y, particle.angle,
                                   particle.width, particle.height, particle.dead});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_states.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_stalled = !rx_stalled;
          rx_hold    = rx_stalled ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end
        rx_hold--;
        out_ready <= !rx_stalled;
      end
    endcase
  end

  task automatic send_item(input logic cmd, input logic [31:0] px, py, vx, vy, ang,
                           input logic [15:0] life);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_cmd         = cmd;
    in_spawn_pos_x = px;
    in_spawn_pos_y = py;
    in_spawn_vel_x = vx;
    in_spawn_vel_y = vy;
    in_spawn_angle = ang;
    in_spawn_life  = life;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // The spawn fields of a tick carry noise that the block must ignore.
  task automatic send_tick();
    send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending_states.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(input logic [31:0] gx, gy, spin, input logic on,
                             input logic [15:0] sw, sh, ew, eh);
    wait_drained();
    write_reg(REG_GRAVITY_X, gx);
    write_reg(REG_GRAVITY_Y, gy);
    write_reg(REG_SPIN_RATE, spin);
    write_reg(REG_SIZE_CHANGE, {31'd0, on});
    write_reg(REG_START_WIDTH, {16'd0, sw});
    write_reg(REG_START_HEIGHT, {16'd0, sh});
    write_reg(REG_END_WIDTH, {16'd0, ew});
    write_reg(REG_END_HEIGHT, {16'd0, eh});
    n_settings++;
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_dead_after_reset();
    send_tick();
    send_tick();
  endtask

  task automatic test_spawn_extremes();
    load_config(32'd0, 32'd0, 32'd0, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(CMD_SPAWN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 16'hFFFF);
    send_item(CMD_SPAWN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 16'h0000);
    send_tick();
    send_tick();
    send_item(CMD_SPAWN, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
              32'hFFFF_FFFF, 16'h0001);
    send_tick();
    send_tick();
  endtask

  task automatic test_motion_wrap();
    load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0,
                16'h0040, 16'h0080, 16'h1000, 16'h2000);
    write_reg(REG_UNUSED, $urandom);
    send_item(CMD_SPAWN, 32'h7FFF_FFF0, 32'h8000_0010, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 16'h0003);
    repeat (4) send_tick();
  endtask

  task automatic test_size_easing();
    load_config(32'h0000_8000, 32'hFFFF_0000, 32'h0000_1000, 1'b1,
                16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_item(CMD_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom, 16'h0002);
    repeat (3) send_tick();
    send_item(CMD_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom, 16'hFFFF);
    repeat (2) send_tick();
    // Registers are read live, so a change mid-life shows on the next tick.
    send_item(CMD_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom, 16'h0005);
    send_tick();
    wait_drained();
    write_reg(REG_END_WIDTH, 32'h0000_1234);
    write_reg(REG_GRAVITY_X, 32'hFFFF_8000);
    send_tick();
    send_tick();
  endtask

  task automatic test_random_lifetimes();
    int          phase;
    int          sent;
    int          ticks;
    logic [15:0] life;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        load_config(pick_rate(), pick_rate(), pick_rate(), 1'b1,
                    16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      end else begin
        load_config(pick_rate(), pick_rate(), pick_rate(), phase[0],
                    pick_size(), pick_size(), pick_size(), pick_size());
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 6) != 0) begin
          life = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
          send_item(CMD_SPAWN, $urandom, $urandom, $urandom, $urandom, $urandom, life);
          ticks = (life > 28) ? $urandom_range(4, 28) : int'(life) + $urandom_range(0, 3);
          repeat (ticks) send_tick();
          sent += 1 + ticks;
        end else begin
          send_item(logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_GRAVITY_X;
    cfg_data       = 32'd0;
    in_valid       = 1'b0;
    in_cmd         = CMD_TICK;
    in_spawn_pos_x = 32'd0;
    in_spawn_pos_y = 32'd0;
    in_spawn_vel_x = 32'd0;
    in_spawn_vel_y = 32'd0;
    in_spawn_angle = 32'd0;
    in_spawn_life  = 16'd0;
    out_ready      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_dead_after_reset();
    test_spawn_extremes();
    test_motion_wrap();
    test_size_easing();
    test_random_lifetimes();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_states.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_states.size()));
    end
    $display("Checked %0d results from %0d spawns and %0d ticks, %0d of them on dead",
             n_results, n_spawns, n_ticks, n_dead_ticks);
    $display("particles, across %0d register settings; %0d mismatches.",
             n_settings, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: particle_euler_step_with_lifetime.f
+incdir+rtl
rtl/pes_pkg.sv
rtl/pes_ctrl.sv
rtl/pes_datapath.sv
rtl/particle_euler_step_with_lifetime.sv
tb/tb_particle_euler_step_with_lifetime.sv
